### design/cbc_pkg.sv
`default_nettype none
package cbc_pkg;

  localparam int SLOT_MASK_W = 10;
  localparam logic [SLOT_MASK_W-1:0] SLOT_MASK_RESET = 10'd1023;
  localparam int HANDLE_W = 64;
  localparam logic [HANDLE_W-1:0] FIB_MUL = 64'd11400714819323198485;
  localparam int HASH_SHIFT = 4;
  localparam int IDX_W = 9;
  localparam int COLOR_W = 4;
  localparam int KIND_W = 4;
  localparam int STATUS_W = 3;
  localparam int SEEN_W = 10;
  localparam int COUNT_W = 2;

  localparam logic [1:0] MODE_DYN = 2'd0;
  localparam logic [1:0] MODE_A_STATIC = 2'd1;
  localparam logic [1:0] MODE_B_STATIC = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_SAME        = 3'd1,
    ST_BOTH_STATIC = 3'd2,
    ST_BAD_COUNT   = 3'd3,
    ST_NO_COLOR    = 3'd4,
    ST_FULL        = 3'd5
  } status_t;

  typedef struct packed {
    logic                first_of_batch;
    logic [HANDLE_W-1:0] handle_a;
    logic [HANDLE_W-1:0] handle_b;
    logic                static_a;
    logic                static_b;
    logic                has_friction;
    logic [COUNT_W-1:0]  contact_count;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]    index_a;
    logic [IDX_W-1:0]    index_b;
    logic [COLOR_W-1:0]  color;
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic [SEEN_W-1:0]   bodies_seen;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic slot_rd;
    logic body_rd;
    logic probe_step;
    logic col_rd_a;
    logic col_rd_b;
    logic col_sel;
    logic col_wr_a;
    logic col_wr_b;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic chk_fail;
    logic hit;
    logic full;
    logic on_b;
    logic no_color;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

### design/cbc_in_if.sv
`default_nettype none
interface cbc_in_if import cbc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/cbc_out_if.sv
`default_nettype none
interface cbc_out_if import cbc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/constraint_batch_colorer.sv
`default_nettype none
// Colors contact constraints in batches: each item's two body handles are
// looked up (or added) in a linear-probing hash store, the lowest color free
// on both dynamic bodies is picked and marked, and one result item follows.
// One item at a time. An item passes through a start step, then per hash
// probe a slot memory read, a body memory read and a compare, then color
// memory reads and updates, and last the result handover; items that fail
// the input check go from the start step straight to the handover. The
// single-port slot, body and color memories set this order of steps.
// After reset the slot memory is zeroed one entry a cycle, so no item is
// taken until all HASH_SLOTS entries (1024 by default) are cleared; after
// that first_of_batch only resets the body count, and a slot counts as
// taken only if its body entry points back at it.
module constraint_batch_colorer import cbc_pkg::*; #(
  parameter int HASH_SLOTS = 1024,
  parameter int MAX_BODIES = 512,
  parameter int NUM_COLORS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [SLOT_MASK_W-1:0] cfg_wdata,
  cbc_in_if.sink                 req,
  cbc_out_if.source              rsp
);
  cmd_t  cmd;
  stat_t st;

  cbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .st       (st)
  );

  cbc_dp #(
    .HASH_SLOTS (HASH_SLOTS),
    .MAX_BODIES (MAX_BODIES),
    .NUM_COLORS (NUM_COLORS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (req.data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp.data),
    .cmd       (cmd),
    .st        (st)
  );
endmodule
`default_nettype wire

### design/cbc_ram.sv
`default_nettype none
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

### design/cbc_ctrl.sv
`default_nettype none
module cbc_ctrl import cbc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output cmd_t  cmd,
  input  stat_t st
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_START = 11'b00000000010,
    S_SRD   = 11'b00000000100,
    S_BRD   = 11'b00000001000,
    S_CMP   = 11'b00000010000,
    S_CRA   = 11'b00000100000,
    S_CRB   = 11'b00001000000,
    S_CSEL  = 11'b00010000000,
    S_WRA   = 11'b00100000000,
    S_WRB   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !st.busy;
        if (in_valid && !st.busy) begin
          cmd.load = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = st.chk_fail ? S_DONE : S_SRD;
      end
      S_SRD: begin
        cmd.slot_rd = 1'b1;
        state_next = S_BRD;
      end
      S_BRD: begin
        cmd.body_rd = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.probe_step = 1'b1;
        if (st.hit) begin
          state_next = st.on_b ? S_CRA : S_SRD;
        end else if (st.full) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SRD;
        end
      end
      S_CRA: begin
        cmd.col_rd_a = 1'b1;
        state_next = S_CRB;
      end
      S_CRB: begin
        cmd.col_rd_b = 1'b1;
        state_next = S_CSEL;
      end
      S_CSEL: begin
        cmd.col_sel = 1'b1;
        state_next = st.no_color ? S_DONE : S_WRA;
      end
      S_WRA: begin
        cmd.col_wr_a = 1'b1;
        state_next = S_WRB;
      end
      S_WRB: begin
        cmd.col_wr_b = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_cmd_single: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");
  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && st.out_free) |=> state == S_IDLE)
    else $error("finished item not released");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    st.busy |-> !cmd.load)
    else $error("item taken while slot memory is cleared");
`endif
endmodule
`default_nettype wire

### design/cbc_dp.sv
`default_nettype none
module cbc_dp import cbc_pkg::*; #(
  parameter int HASH_SLOTS = 1024,
  parameter int MAX_BODIES = 512,
  parameter int NUM_COLORS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [SLOT_MASK_W-1:0] cfg_wdata,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  cmd_t                   cmd,
  output stat_t                  st
);
  localparam int SW = $clog2(HASH_SLOTS);
  localparam int IW = $clog2(MAX_BODIES);
  localparam int TW = IW + 1;
  localparam int NC = NUM_COLORS;
  localparam int CW = $clog2(NUM_COLORS);
  localparam int BW = SW + HANDLE_W;
  localparam logic [31:0] SLOT_LIM = 32'(HASH_SLOTS - 1);
  localparam logic [TW-1:0] MAX_T = TW'(MAX_BODIES);
  localparam logic [SW-1:0] FIB_LOW = FIB_MUL[SW-1:0];
  localparam logic [SW-1:0] CLR_LAST = SW'(HASH_SLOTS - 1);

  logic [SLOT_MASK_W-1:0] slot_mask;
  logic [SW-1:0]          mask_eff;
  in_item_t               item;
  logic                   on_b;
  logic [SW-1:0]          slot;
  logic [SW-1:0]          n;
  logic [IW-1:0]          ia;
  logic [IW-1:0]          ib;
  logic [TW-1:0]          total;
  status_t                status;
  logic [NC-1:0]          mask_a;
  logic [NC-1:0]          mask_b;
  logic [CW-1:0]          color;
  logic [KIND_W-1:0]      kind;
  logic                   clearing;
  logic [SW-1:0]          clr_addr;

  logic [IW-1:0]          bi;
  logic [BW-1:0]          body_rdata;
  logic [SW-1:0]          b_slot;
  logic [HANDLE_W-1:0]    b_handle;
  logic [NC-1:0]          col_rdata;
  logic [HANDLE_W-1:0]    cur_handle;
  logic                   slot_live;
  logic                   hit_now;
  logic                   ins_now;
  logic                   full_now;
  logic                   ins;
  logic [IW-1:0]          found_idx;
  logic [NC-1:0]          used;
  logic [CW-1:0]          c_sel;
  logic                   c_found;
  logic [NC-1:0]          free_bit;
  logic [1:0]             mode;

  logic                   slot_we;
  logic [SW-1:0]          slot_addr;
  logic [IW-1:0]          slot_wdata;
  logic                   body_we;
  logic [IW-1:0]          body_addr;
  logic                   col_we;
  logic                   col_re;
  logic [IW-1:0]          col_addr;
  logic [NC-1:0]          col_wdata;

  function automatic logic [SW-1:0] slot_hash(input logic [HANDLE_W-1:0] h,
                                              input logic [SW-1:0] m);
    logic [2*SW-1:0] p;
    p = h[SW+HASH_SHIFT-1:HASH_SHIFT] * FIB_LOW;
    return p[SW-1:0] & m;
  endfunction

  function automatic status_t check_code(input in_item_t d);
    status_t s;
    s = ST_OK;
    if (d.handle_a == d.handle_b) begin
      s = ST_SAME;
    end else if (d.static_a && d.static_b) begin
      s = ST_BOTH_STATIC;
    end else if (d.contact_count == 2'd0 || d.contact_count == 2'd3) begin
      s = ST_BAD_COUNT;
    end
    return s;
  endfunction

  assign mask_eff = SW'({{(32-SLOT_MASK_W){1'b0}}, slot_mask} & SLOT_LIM);
  assign cur_handle = on_b ? item.handle_b : item.handle_a;
  assign {b_slot, b_handle} = body_rdata;

  // slot is live in this batch only if its body points back at it
  assign slot_live = ({1'b0, bi} < total) && (b_slot == slot);
  assign hit_now = slot_live && (b_handle == cur_handle);
  assign ins_now = !slot_live && (total < MAX_T);
  assign full_now = (!slot_live && (total >= MAX_T)) || (slot_live && !hit_now && n == mask_eff);
  assign ins = cmd.probe_step && ins_now;
  assign found_idx = hit_now ? bi : total[IW-1:0];

  always_comb begin
    used = (item.static_a ? '0 : mask_a) | (item.static_b ? '0 : col_rdata);
    c_sel = '0;
    c_found = 1'b0;
    for (int i = NC - 1; i >= 0; i--) begin
      if (!used[i]) begin
        c_sel = CW'(i);
        c_found = 1'b1;
      end
    end
  end

  assign free_bit = NC'(1) << color;
  assign mode = item.static_a ? MODE_A_STATIC : (item.static_b ? MODE_B_STATIC : MODE_DYN);

  assign st.busy = clearing;
  assign st.chk_fail = (status != ST_OK);
  assign st.hit = hit_now || ins_now;
  assign st.full = full_now;
  assign st.on_b = on_b;
  assign st.no_color = !c_found;
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_mask <= SLOT_MASK_RESET;
      total <= '0;
      out_valid <= 1'b0;
      on_b <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + SW'(1);
        if (clr_addr == CLR_LAST) begin
          clearing <= 1'b0;
        end
      end
      if (cfg_we) begin
        slot_mask <= cfg_wdata;
      end
      if (cmd.load) begin
        item <= in_data;
        on_b <= 1'b0;
        slot <= slot_hash(in_data.handle_a, mask_eff);
        n <= '0;
        ia <= '0;
        ib <= '0;
        color <= '0;
        kind <= '0;
        status <= check_code(in_data);
        if (in_data.first_of_batch) begin
          total <= '0;
        end
      end
      if (cmd.probe_step) begin
        if (hit_now || ins_now) begin
          if (ins_now) begin
            total <= total + TW'(1);
          end
          if (on_b) begin
            ib <= found_idx;
          end else begin
            ia <= found_idx;
            on_b <= 1'b1;
            slot <= slot_hash(item.handle_b, mask_eff);
            n <= '0;
          end
        end else if (full_now) begin
          status <= ST_FULL;
        end else begin
          slot <= (slot + SW'(1)) & mask_eff;
          n <= n + SW'(1);
        end
      end
      if (cmd.col_rd_b) begin
        mask_a <= col_rdata;
      end
      if (cmd.col_sel) begin
        mask_b <= col_rdata;
        if (c_found) begin
          color <= c_sel;
          kind <= {mode, item.has_friction, item.contact_count[1]};
        end else begin
          status <= ST_NO_COLOR;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.index_a <= IDX_W'(ia);
      out_data.index_b <= IDX_W'(ib);
      out_data.color <= COLOR_W'(color);
      out_data.kind <= kind;
      out_data.status <= status;
      out_data.bodies_seen <= SEEN_W'(total);
    end
  end

  // zero the slot memory once after reset
  assign slot_we = ins || clearing;
  assign slot_addr = clearing ? clr_addr : slot;
  assign slot_wdata = clearing ? '0 : total[IW-1:0];

  assign body_we = ins;
  assign body_addr = cmd.body_rd ? bi : total[IW-1:0];

  always_comb begin
    col_we = 1'b0;
    col_addr = ib;
    col_wdata = mask_b | free_bit;
    if (ins) begin
      col_we = 1'b1;
      col_addr = total[IW-1:0];
      col_wdata = '0;
    end else if (cmd.col_rd_a || cmd.col_wr_a) begin
      col_we = cmd.col_wr_a && !item.static_a;
      col_addr = ia;
      col_wdata = mask_a | free_bit;
    end else if (cmd.col_wr_b) begin
      col_we = !item.static_b;
    end
  end
  assign col_re = cmd.col_rd_a || cmd.col_rd_b;

  cbc_ram #(.WIDTH(IW), .DEPTH(HASH_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .re    (cmd.slot_rd),
    .addr  (slot_addr),
    .wdata (slot_wdata),
    .rdata (bi)
  );

  cbc_ram #(.WIDTH(BW), .DEPTH(MAX_BODIES)) u_body_ram (
    .clk   (clk),
    .we    (body_we),
    .re    (cmd.body_rd),
    .addr  (body_addr),
    .wdata ({slot, cur_handle}),
    .rdata (body_rdata)
  );

  cbc_ram #(.WIDTH(NC), .DEPTH(MAX_BODIES)) u_color_ram (
    .clk   (clk),
    .we    (col_we),
    .re    (col_re),
    .addr  (col_addr),
    .wdata (col_wdata),
    .rdata (col_rdata)
  );

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk) disable iff (rst) total <= MAX_T)
    else $error("body count beyond store size");
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ins |=> total == $past(total) + TW'(1))
    else $error("insert did not advance body count");
  a_color_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd.col_wr_a || cmd.col_wr_b) |-> status == ST_OK)
    else $error("color marked on a rejected item");
`endif
endmodule
`default_nettype wire
